FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, entry and broadcast types,
// command and status codes. No dependencies; every other file imports it.
`default_nettype none
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W = 16;
	localparam int VAL_W = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	// What every cell sees in the same cycle: the operation and the new entry.
	typedef struct packed {
		logic   do_insert;
		logic   do_pop;
		entry_t item;
	} bcast_t;

endpackage
`default_nettype wire

FILE: rtl/spq_cell.sv
// One cell of the sorted queue: holds one entry and updates it from the
// broadcast item or a neighbor. Depends on spq_pkg.
`default_nettype none
module spq_cell import spq_pkg::*; (
	input  wire logic   clk,
	input  wire bcast_t bcast,
	input  wire logic   is_head,
	input  wire logic   valid,
	input  wire logic   left_cond,
	input  wire entry_t left_entry,
	input  wire entry_t right_entry,
	output logic        cond,
	output entry_t      entry
);

	entry_t entry_q;

	// True when the new entry belongs at or before this cell. The head lets an
	// equal key go behind it; every other cell yields on equal keys.
	always_comb begin
		cond = !valid
			|| (entry_q.key > bcast.item.key)
			|| ((entry_q.key == bcast.item.key) && !is_head);
	end

	always_ff @(posedge clk) begin
		if (bcast.do_insert) begin
			if (cond && !left_cond) begin
				entry_q <= bcast.item;
			end else if (cond) begin
				entry_q <= left_entry;
			end
		end else if (bcast.do_pop) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: the row of spq_cell instances, the
// entry count and the result register. Depends on spq_pkg and spq_cell.
`default_nettype none
// The queue holds up to QUEUE_DEPTH (key, value) entries in ascending key
// order, one entry per cell, so the head is always the lowest key. Each input
// beat carries an insert or a pop, and each yields exactly one result beat
// with a status, the popped entry (zero for anything but a successful pop),
// and the head, empty flag and count after the command. A new entry goes in
// front of the first entry with a greater or equal key, except that an entry
// whose key equals the head's key goes right behind the head. An insert into
// a full queue and a pop from an empty one are reported and change nothing.
// The block takes one input beat per clock cycle: every cell compares its
// key with the broadcast key in parallel and takes the new entry, its left
// neighbor (insert) or its right neighbor (pop) at the same edge, so the
// cycle is set by one 16-bit compare in a cell plus the head selection. The
// result sits in an output register; the input stalls only while that
// register is full and the output is stalled. There is no clearing pass
// after reset; the contents of cells at or beyond the count never reach an output.
module sorted_priority_queue import spq_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    command,
	input  wire logic [KEY_W-1:0]        item_key,
	input  wire logic signed [VAL_W-1:0] item_value,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [1:0]                   status,
	output logic [KEY_W-1:0]             removed_key,
	output logic signed [VAL_W-1:0]      removed_value,
	output logic [KEY_W-1:0]             head_key,
	output logic signed [VAL_W-1:0]      head_value,
	output logic                         is_empty,
	output logic [CNT_W-1:0]             entry_count
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             accept;
	logic             is_full;
	logic             is_none;
	bcast_t           bcast;
	status_t          status_next;
	entry_t           head_next;
	entry_t           removed_next;

	entry_t           entries [QUEUE_DEPTH];
	logic             conds   [QUEUE_DEPTH];

	logic             out_valid_q;
	status_t          status_q;
	entry_t           removed_q;
	entry_t           head_q;
	logic             empty_q;
	logic [CNT_W-1:0] count_out_q;

	// A beat is taken unless a result is waiting that cannot leave this cycle.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign is_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_none = (count_q == '0);

	always_comb begin
		bcast.do_insert  = accept && (command == CMD_INSERT) && !is_full;
		bcast.do_pop     = accept && (command == CMD_POP) && !is_none;
		bcast.item.key   = item_key;
		bcast.item.value = item_value;
	end

	// The row of cells. A cell is valid when its position is below the count;
	// the first cell has no left neighbor and the last has no right one.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   cell_valid;
		logic   cell_left_cond;
		entry_t cell_left;
		entry_t cell_right;

		assign cell_valid = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign cell_left_cond = 1'b0;
			assign cell_left      = '0;
		end else begin : g_inner
			assign cell_left_cond = conds[i-1];
			assign cell_left      = entries[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign cell_right = '0;
		end else begin : g_body
			assign cell_right = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.bcast       (bcast),
			.is_head     (i == 0),
			.valid       (cell_valid),
			.left_cond   (cell_left_cond),
			.left_entry  (cell_left),
			.right_entry (cell_right),
			.cond        (conds[i]),
			.entry       (entries[i])
		);
	end

	// Outcome of the current command and the head the first cell will hold.
	always_comb begin
		status_next  = STAT_DONE;
		count_next   = count_q;
		head_next    = entries[0];
		removed_next = '0;
		if (command == CMD_INSERT) begin
			if (is_full) begin
				status_next = STAT_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
				if (conds[0]) begin
					head_next = bcast.item;
				end
			end
		end else begin
			if (is_none) begin
				status_next = STAT_EMPTY;
			end else begin
				count_next   = count_q - CNT_W'(1);
				head_next    = entries[1];
				removed_next = entries[0];
			end
		end
		if (count_next == '0) begin
			head_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_next;
			removed_q   <= removed_next;
			head_q      <= head_next;
			empty_q     <= (count_next == '0);
			count_out_q <= count_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_key   = removed_q.key;
	assign removed_value = removed_q.value;
	assign head_key      = head_q.key;
	assign head_value    = head_q.value;
	assign is_empty      = empty_q;
	assign entry_count   = count_out_q;

endmodule
`default_nettype wire
